// ===== hdl/set_assoc_cache_lru_asid_defines.svh =====
// assertion macros used by the cache back sequencer
`ifndef SET_ASSOC_CACHE_LRU_ASID_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_ASID_DEFINES_SVH

// same-cycle implication, off during reset
`define SACL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacl assertion failed");

// next-cycle implication, off during reset
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacl assertion failed");

`endif

// ===== hdl/sacl_pkg.sv =====
package sacl_pkg;

    localparam int DEF_SET_BITS     = 6;
    localparam int DEF_LINE_BITS    = 3;
    localparam int DEF_WAYS         = 4;
    localparam int DEF_ADDRESS_BITS = 32;

    localparam int ASID_W      = 16;
    localparam int MAX_BYTES   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] ALL_ONES = 32'hffffffff;

    typedef enum logic [2:0] {
        ACT_PROBE = 3'd0,
        ACT_READ  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_FILL  = 3'd3,
        ACT_INVAL = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAG,
        ST_CMP,
        ST_DATA,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        HIT_NONE    = 2'd0,
        HIT_SINGLE  = 2'd1,
        HIT_PARTIAL = 2'd2,
        HIT_BOTH    = 2'd3
    } t_hit;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]                 action;
        logic [31:0]                line0;
        logic [31:0]                line1;
        logic [ASID_W-1:0]          asid;
        logic                       spans;
        logic [MAX_BYTES-1:0]       sel0;
        logic [MAX_BYTES-1:0]       sel1;
        logic [MAX_BYTES-1:0][2:0]  off;
        logic [63:0]                data;
    } t_req;

endpackage

// ===== hdl/sacl_if.sv =====
interface sacl_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] address;
    logic [15:0] asid;
    logic [2:0]  byte_count;
    logic [63:0] data;

    modport source (output valid, action, address, asid, byte_count, data, input ready);
    modport sink   (input valid, action, address, asid, byte_count, data, output ready);
endinterface

interface sacl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  hit_status;
    logic [31:0] read_data;

    modport source (output valid, hit_status, read_data, input ready);
    modport sink   (input valid, hit_status, read_data, output ready);
endinterface

// ===== hdl/set_assoc_cache_lru_asid.sv =====
// Set-associative cache with address-space-qualified tags and rank-based LRU. A front stage
// classifies each request (line numbers, span, per-byte line and offset) into a two-deep
// queue; a back sequencer then walks each line through a tag/rank/valid row read, a compare
// cycle that writes ranks, tags, valid bits or bytes, and for read hits a data read, and
// finally loads the result register. Fill, invalidate and unknown actions visit one line
// only; a split probe, write or read visits both lines, and a read takes the data read on
// each line that hits. A result register still held by the receiver stalls the sequencer
// at the end. Valid bits and rank-row flags reset at once, so no clearing pass is needed.
module set_assoc_cache_lru_asid
    import sacl_pkg::*;
#(
    parameter int SET_BITS     = DEF_SET_BITS,
    parameter int LINE_BITS    = DEF_LINE_BITS,
    parameter int WAYS         = DEF_WAYS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sacl_in_if.sink    i_in,
    sacl_out_if.source o_out
);

    t_req q_in_data;
    t_req q_out_data;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    sacl_front #(
        .LINE_BITS    (LINE_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (q_push),
        .o_req  (q_in_data)
    );

    sacl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .i_pop   (q_pop),
        .o_data  (q_out_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sacl_back #(
        .SET_BITS     (SET_BITS),
        .LINE_BITS    (LINE_BITS),
        .WAYS         (WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_out_data),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// ===== hdl/sacl_front.sv =====
module sacl_front
    import sacl_pkg::*;
#(
    parameter int LINE_BITS    = DEF_LINE_BITS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    sacl_in_if.sink i_in,
    input  logic    i_full,
    output logic    o_push,
    output t_req    o_req
);

    localparam logic [31:0] ADDR_MASK = ALL_ONES >> (32 - ADDRESS_BITS);
    localparam logic [31:0] LN_MASK   = ADDR_MASK >> LINE_BITS;
    localparam logic [31:0] OFF_MASK  = (32'd1 << LINE_BITS) - 32'd1;

    always_comb begin
        logic [31:0] addr;
        logic [31:0] last;
        logic [31:0] a;
        logic [31:0] ln;
        logic [2:0]  cnt;
        logic        en;
        addr = i_in.address & ADDR_MASK;
        cnt  = i_in.byte_count;
        if (cnt == 3'd0) begin
            cnt = 3'd1;
        end else if (cnt > 3'd4) begin
            cnt = 3'd4;
        end
        o_req.action = i_in.action;
        o_req.asid   = i_in.asid;
        o_req.data   = i_in.data;
        o_req.line0  = addr >> LINE_BITS;
        last         = (addr + {29'd0, cnt} - 32'd1) & ADDR_MASK;
        o_req.spans  = (last >> LINE_BITS) != o_req.line0;
        o_req.line1  = (o_req.line0 + 32'd1) & LN_MASK;
        // which line each byte lands in; bytes past the second line drop out
        for (int i = 0; i < MAX_BYTES; i++) begin
            a  = (addr + 32'(i)) & ADDR_MASK;
            ln = a >> LINE_BITS;
            en = 3'(i) < cnt;
            o_req.sel0[i] = en && (ln == o_req.line0);
            o_req.sel1[i] = en && !o_req.sel0[i] && o_req.spans && (ln == o_req.line1);
            o_req.off[i]  = 3'(a & OFF_MASK);
        end
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

endmodule

// ===== hdl/sacl_queue.sv =====
module sacl_queue
    import sacl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    input  logic i_pop,
    output t_req o_data,
    output logic o_full,
    output logic o_empty
);

    t_req       r_mem [QUEUE_DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = r_count == 2'(QUEUE_DEPTH);
    assign o_empty = r_count == 2'd0;

endmodule

// ===== hdl/sacl_back.sv =====
module sacl_back
    import sacl_pkg::*;
#(
    parameter int SET_BITS     = DEF_SET_BITS,
    parameter int LINE_BITS    = DEF_LINE_BITS,
    parameter int WAYS         = DEF_WAYS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  logic     i_empty,
    output logic     o_pop,
    sacl_out_if.source o_out
);

`include "set_assoc_cache_lru_asid_defines.svh"

    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int SI_W      = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W     = ADDRESS_BITS - SET_BITS - LINE_BITS;
    localparam int TA_W      = TAG_W + ASID_W;
    localparam int WB        = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRIES   = NUM_SETS * WAYS;
    localparam int EB        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LINE_SIZE = 1 << LINE_BITS;
    localparam int LINE_W    = 8 * LINE_SIZE;
    localparam logic [31:0] SET_MASK = 32'(NUM_SETS - 1);

    function automatic logic [EB-1:0] ent(input logic [SI_W-1:0] s, input logic [WB-1:0] w);
        return EB'(int'(s) * WAYS + int'(w));
    endfunction

    // memories: tag and space id per set row, ranks per set row, line bytes per entry
    logic [WAYS*TA_W-1:0] tag_mem  [NUM_SETS];
    logic [WAYS*WB-1:0]   rank_mem [NUM_SETS];
    logic [LINE_W-1:0]    data_mem [ENTRIES];

    logic [WAYS-1:0]      r_valid   [NUM_SETS];
    logic                 r_rank_ok [NUM_SETS];

    t_state               r_state, n_state;
    t_req                 r_req;
    logic                 r_idx;
    logic [1:0]           r_hit;
    logic [31:0]          r_rdata;
    logic [WAYS*TA_W-1:0] r_ta_q;
    logic [WAYS*WB-1:0]   r_rank_q;
    logic                 r_rank_okq;
    logic [WAYS-1:0]      r_valid_q;
    logic [LINE_W-1:0]    r_data_q;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [31:0]          r_out_data;

    logic [31:0]          cur_line;
    logic [SI_W-1:0]      cur_set;
    logic [TAG_W-1:0]     cur_tag;
    logic [MAX_BYTES-1:0] cur_sel;
    logic                 any_hit;
    logic [WB-1:0]        hit_way;
    logic                 vic_found;
    logic [WB-1:0]        vic_way;
    logic [WB-1:0]        eff_rank [WAYS];
    logic [WAYS*WB-1:0]   rank_rd_row;
    logic [WAYS*WB-1:0]   rank_iv_row;
    logic                 rank_we;
    logic [WAYS*WB-1:0]   rank_wrow;
    logic                 ta_we;
    logic [WAYS*TA_W-1:0] ta_wrow;
    logic [LINE_SIZE-1:0] dm_we;
    logic [LINE_W-1:0]    dm_wdata;
    logic [EB-1:0]        dm_ent;
    logic                 v_set;
    logic                 v_clr;
    logic                 out_load;
    logic [1:0]           status;
    logic                 is_access;

    assign cur_line  = r_idx ? r_req.line1 : r_req.line0;
    assign cur_set   = SI_W'(cur_line & SET_MASK);
    assign cur_tag   = TAG_W'(cur_line >> SET_BITS);
    assign cur_sel   = r_idx ? r_req.sel1 : r_req.sel0;
    assign is_access = (r_req.action == ACT_PROBE) || (r_req.action == ACT_READ)
                    || (r_req.action == ACT_WRITE);

    // lookup, victim choice and the rank rows derived from one set read
    always_comb begin
        logic [TA_W-1:0] ta;
        logic [WB-1:0]   r;
        any_hit   = 1'b0;
        hit_way   = '0;
        vic_found = 1'b0;
        vic_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            eff_rank[w] = r_rank_okq ? r_rank_q[w*WB +: WB] : '0;
            ta = r_ta_q[w*TA_W +: TA_W];
            if (!any_hit && r_valid_q[w] && ta == {cur_tag, r_req.asid}) begin
                any_hit = 1'b1;
                hit_way = WB'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (!vic_found && !r_valid_q[w]) begin
                vic_found = 1'b1;
                vic_way   = WB'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (!vic_found && eff_rank[w] == '0) begin
                vic_found = 1'b1;
                vic_way   = WB'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            r = eff_rank[w];
            if (r >= eff_rank[hit_way] && r != '0) begin
                r = r - WB'(1);
            end
            rank_rd_row[w*WB +: WB] = (WB'(w) == hit_way) ? WB'(WAYS - 1) : r;
            rank_iv_row[w*WB +: WB] = (WB'(w) == hit_way) ? '0 : eff_rank[w];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_TAG;
                end
            end
            ST_TAG: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_req.action == ACT_READ && any_hit) begin
                    n_state = ST_DATA;
                end else if (is_access && !r_idx && r_req.spans) begin
                    n_state = ST_TAG;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DATA: begin
                n_state = (!r_idx && r_req.spans) ? ST_TAG : ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        out_load  = 1'b0;
        rank_we   = 1'b0;
        rank_wrow = rank_rd_row;
        ta_we     = 1'b0;
        ta_wrow   = r_ta_q;
        dm_we     = '0;
        dm_wdata  = '0;
        dm_ent    = ent(cur_set, hit_way);
        v_set     = 1'b0;
        v_clr     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop = !i_empty;
            end
            ST_CMP: begin
                case (r_req.action)
                    ACT_READ: begin
                        rank_we = any_hit;
                    end
                    ACT_WRITE: begin
                        for (int o = 0; o < LINE_SIZE; o++) begin
                            for (int i = 0; i < MAX_BYTES; i++) begin
                                if (any_hit && cur_sel[i] && r_req.off[i] == 3'(o)) begin
                                    dm_we[o]           = 1'b1;
                                    dm_wdata[8*o +: 8] = r_req.data[8*i +: 8];
                                end
                            end
                        end
                    end
                    ACT_FILL: begin
                        dm_ent = ent(cur_set, vic_way);
                        if (vic_found) begin
                            ta_we = 1'b1;
                            ta_wrow[int'(vic_way)*TA_W +: TA_W] = {cur_tag, r_req.asid};
                            dm_we    = '1;
                            dm_wdata = r_req.data[LINE_W-1:0];
                            v_set    = 1'b1;
                        end
                    end
                    ACT_INVAL: begin
                        rank_we   = any_hit;
                        rank_wrow = rank_iv_row;
                        v_clr     = any_hit;
                    end
                    default: ;
                endcase
            end
            ST_DONE: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (!r_req.spans) begin
            status = r_hit[0] ? HIT_SINGLE : HIT_NONE;
        end else if (r_hit[0] && r_hit[1]) begin
            status = HIT_BOTH;
        end else if (r_hit[0] || r_hit[1]) begin
            status = HIT_PARTIAL;
        end else begin
            status = HIT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_TAG) begin
            r_ta_q     <= tag_mem[cur_set];
            r_rank_q   <= rank_mem[cur_set];
            r_rank_okq <= r_rank_ok[cur_set];
            r_valid_q  <= r_valid[cur_set];
        end
        if (ta_we) begin
            tag_mem[cur_set] <= ta_wrow;
        end
        if (rank_we) begin
            rank_mem[cur_set] <= rank_wrow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CMP) begin
            r_data_q <= data_mem[dm_ent];
        end
        for (int o = 0; o < LINE_SIZE; o++) begin
            if (dm_we[o]) begin
                data_mem[dm_ent][8*o +: 8] <= dm_wdata[8*o +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s]   <= '0;
                r_rank_ok[s] <= 1'b0;
            end
        end else begin
            if (v_set) begin
                r_valid[cur_set][vic_way] <= 1'b1;
            end
            if (v_clr) begin
                r_valid[cur_set][hit_way] <= 1'b0;
            end
            if (rank_we) begin
                r_rank_ok[cur_set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_idx <= 1'b0;
            end else if ((r_state == ST_CMP || r_state == ST_DATA) && n_state == ST_TAG) begin
                r_idx <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req   <= i_req;
            r_hit   <= 2'b00;
            r_rdata <= '0;
        end
        if (r_state == ST_CMP && is_access) begin
            r_hit[r_idx] <= any_hit;
        end
        if (r_state == ST_DATA) begin
            for (int i = 0; i < MAX_BYTES; i++) begin
                if (cur_sel[i]) begin
                    r_rdata[8*i +: 8] <= r_data_q[8*int'(r_req.off[i][LINE_BITS-1:0]) +: 8];
                end
            end
        end
        if (out_load) begin
            r_out_status <= is_access ? status : HIT_NONE;
            r_out_data   <= (r_req.action == ACT_READ
                            && (status == HIT_SINGLE || status == HIT_BOTH)) ? r_rdata : '0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hit_status = r_out_status;
    assign o_out.read_data  = r_out_data;

    `SACL_ASSERT_IMPL(a_data_after_cmp, i_clk, i_rst_n, r_state == ST_DATA, $past(r_state) == ST_CMP)
    `SACL_ASSERT_IMPL(a_second_line_spans, i_clk, i_rst_n, r_state == ST_CMP && r_idx, r_req.spans && is_access)
    `SACL_ASSERT_IMPL(a_hit1_needs_span, i_clk, i_rst_n, r_state == ST_DONE && r_hit[1], r_req.spans)
    `SACL_ASSERT_NEXT(a_fill_one_pass, i_clk, i_rst_n, r_state == ST_CMP && r_req.action == ACT_FILL, r_state == ST_DONE)

endmodule

// ===== test/tb_set_assoc_cache_lru_asid.sv =====
module tb_set_assoc_cache_lru_asid;
    import sacl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS  = 1 << DEF_SET_BITS;
    localparam int LBITS = DEF_LINE_BITS;
    localparam int NW    = DEF_WAYS;
    localparam int LIMIT = 400000;
    localparam logic [31:0] LN_MASK = 32'hffffffff >> LBITS;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] address;
        logic [15:0] asid;
        logic [2:0]  byte_count;
        logic [63:0] data;
    } t_item;

    typedef struct packed {
        logic [1:0]  hit_status;
        logic [31:0] read_data;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sacl_in_if  in_ch ();
    sacl_out_if out_ch ();

    set_assoc_cache_lru_asid dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the cache
    logic        sh_valid [SETS][NW];
    logic [31:0] sh_tag   [SETS][NW];
    logic [15:0] sh_asid  [SETS][NW];
    int          sh_rank  [SETS][NW];
    logic [63:0] sh_bytes [SETS][NW];

    t_item pending_items[$];
    t_resp expected_resps[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    quiet = 0;
    bit    in_done = 0;
    int    hold_off = 0;
    bit    in_fire = 0;
    int    gap_left = 0;

    function automatic void queue_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic int find_way(logic [31:0] ln, logic [15:0] asid);
        int s;
        s = ln % SETS;
        for (int w = 0; w < NW; w++)
            if (sh_valid[s][w] && sh_asid[s][w] == asid && sh_tag[s][w] == (ln >> DEF_SET_BITS))
                return w;
        return -1;
    endfunction

    function automatic void promote(int s, int w);
        int prev;
        prev = sh_rank[s][w];
        for (int x = 0; x < NW; x++)
            if (sh_rank[s][x] >= prev && sh_rank[s][x] > 0) sh_rank[s][x]--;
        sh_rank[s][w] = NW - 1;
    endfunction

    function automatic t_resp cache_access(t_item it);
        t_resp r;
        logic [31:0] ln0, ln1, a, ln;
        int cnt, w0, w1, e, s, sft, victim;
        bit spans;
        r = '0;
        ln0 = it.address >> LBITS;
        ln1 = (ln0 + 1) & LN_MASK;
        cnt = it.byte_count;
        if (cnt == 0) cnt = 1;
        if (cnt > 4) cnt = 4;
        spans = ((it.address + cnt - 1) >> LBITS) != ln0;
        if (it.action <= ACT_WRITE) begin
            w0 = find_way(ln0, it.asid);
            w1 = spans ? find_way(ln1, it.asid) : -1;
            if (!spans) r.hit_status = (w0 >= 0) ? HIT_SINGLE : HIT_NONE;
            else if (w0 >= 0 && w1 >= 0) r.hit_status = HIT_BOTH;
            else if (w0 >= 0 || w1 >= 0) r.hit_status = HIT_PARTIAL;
            if (it.action == ACT_READ) begin
                if (w0 >= 0) promote(ln0 % SETS, w0);
                if (w1 >= 0) promote(ln1 % SETS, w1);
            end
            if (it.action == ACT_WRITE || (it.action == ACT_READ &&
                (r.hit_status == HIT_SINGLE || r.hit_status == HIT_BOTH))) begin
                for (int i = 0; i < cnt; i++) begin
                    a = it.address + i;
                    ln = a >> LBITS;
                    sft = 8 * (a % (1 << LBITS));
                    e = -1;
                    if (ln == ln0) e = w0;
                    else if (spans && ln == ln1) e = w1;
                    if (e < 0) continue;
                    s = ln % SETS;
                    if (it.action == ACT_READ)
                        r.read_data[8*i +: 8] = sh_bytes[s][e][sft +: 8];
                    else
                        sh_bytes[s][e][sft +: 8] = it.data[8*i +: 8];
                end
            end
            if (it.action != ACT_READ) r.read_data = '0;
        end else if (it.action == ACT_FILL) begin
            s = ln0 % SETS;
            victim = -1;
            for (int w = 0; w < NW && victim < 0; w++) if (!sh_valid[s][w]) victim = w;
            for (int w = 0; w < NW && victim < 0; w++) if (sh_rank[s][w] == 0) victim = w;
            if (victim >= 0) begin
                sh_valid[s][victim] = 1'b1;
                sh_tag[s][victim]   = ln0 >> DEF_SET_BITS;
                sh_asid[s][victim]  = it.asid;
                sh_bytes[s][victim] = it.data;
            end
        end else if (it.action == ACT_INVAL) begin
            e = find_way(ln0, it.asid);
            if (e >= 0) begin
                sh_valid[ln0 % SETS][e] = 1'b0;
                sh_rank[ln0 % SETS][e] = 0;
            end
        end
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                void'(pending_items.pop_front());
            end
            if (in_ch.valid && !in_fire) begin
                // keep offering the same transaction
            end else if (pending_items.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (!quiet && gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap_left <= $urandom_range(1, 15) - 1;
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid      <= 1'b1;
                in_ch.action     <= pending_items[0].action;
                in_ch.address    <= pending_items[0].address;
                in_ch.asid       <= pending_items[0].asid;
                in_ch.byte_count <= pending_items[0].byte_count;
                in_ch.data       <= pending_items[0].data;
            end
        end
    end

    // predictor runs on accepted input transactions
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            expected_resps.insert(expected_resps.size(),
                cache_access(t_item'{in_ch.action, in_ch.address,
                in_ch.asid, in_ch.byte_count, in_ch.data}));
    end

    // monitor
    always @(posedge i_clk) begin
        t_resp exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_resps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d %h",
                    out_ch.hit_status, out_ch.read_data);
            end else begin
                exp_r = expected_resps.pop_front();
                if (exp_r.hit_status !== out_ch.hit_status ||
                    exp_r.read_data !== out_ch.read_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit %0d data %h, got hit %0d data %h",
                            exp_r.hit_status, exp_r.read_data,
                            out_ch.hit_status, out_ch.read_data);
                end
            end
        end
    end

    // receiver ready with random bursts of stall
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else if (quiet) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 15) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_item rand_item(bit well_formed);
        t_item it;
        logic [31:0] base;
        it.action = 3'($urandom_range(0, 4));
        if (!well_formed && $urandom_range(0, 3) == 0) it.action = 3'($urandom_range(5, 7));
        // a small pool of lines and ids so hits and evictions happen
        base = ($urandom_range(0, 1) ? 32'hfffff000 : 32'h0) |
            ($urandom_range(0, 5) << (LBITS + DEF_SET_BITS)) |
            ($urandom_range(0, 3) << LBITS) | $urandom_range(0, 7);
        if (!well_formed) base = $urandom;
        it.address = base;
        it.asid = well_formed ? 16'($urandom_range(0, 1) ? 16'hffff : 16'h0003) : 16'($urandom);
        it.byte_count = well_formed ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
        it.data = {$urandom, $urandom};
        return it;
    endfunction

    task automatic wait_drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_resps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        t_item it;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_PROBE;
        in_ch.address = '0;
        in_ch.asid = '0;
        in_ch.byte_count = 3'd1;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < NW; w++) begin
                sh_valid[s][w] = 0; sh_tag[s][w] = 0; sh_asid[s][w] = 0;
                sh_rank[s][w] = 0; sh_bytes[s][w] = 0;
            end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: fills at both ends of the address space, split accesses,
        // wrap past the top, odd byte counts, unknown actions, invalidate
        queue_item(t_item'{ACT_PROBE, 32'h0, 16'h0, 3'd1, 64'h0});
        queue_item(t_item'{ACT_FILL, 32'h0, 16'h0, 3'd4, 64'h0807060504030201});
        queue_item(t_item'{ACT_FILL, 32'h8, 16'h0, 3'd4, 64'h100f0e0d0c0b0a09});
        queue_item(t_item'{ACT_FILL, 32'hfffffff8, 16'hffff, 3'd4, '1});
        queue_item(t_item'{ACT_READ, 32'h0, 16'h0, 3'd0, '0});
        queue_item(t_item'{ACT_READ, 32'h6, 16'h0, 3'd4, '0});
        queue_item(t_item'{ACT_PROBE, 32'h6, 16'h0, 3'd7, '0});
        queue_item(t_item'{ACT_WRITE, 32'h5, 16'h0, 3'd4, 64'hdeadbeef});
        queue_item(t_item'{ACT_READ, 32'h5, 16'h0, 3'd5, '0});
        queue_item(t_item'{ACT_READ, 32'he, 16'h0, 3'd4, '0});
        queue_item(t_item'{ACT_READ, 32'hfffffffe, 16'hffff, 3'd4, '0});
        queue_item(t_item'{ACT_WRITE, 32'hffffffff, 16'hffff, 3'd6, '1});
        queue_item(t_item'{ACT_READ, 32'h0, 16'h1, 3'd1, '0});
        queue_item(t_item'{3'd5, 32'h0, 16'h0, 3'd1, '1});
        queue_item(t_item'{3'd7, 32'hffffffff, 16'hffff, 3'd7, '1});
        for (int k = 0; k < 6; k++)
            queue_item(t_item'{ACT_FILL, 32'h200 * k, 16'h0, 3'd1, {2{32'(k)}}});
        queue_item(t_item'{ACT_INVAL, 32'h0, 16'h0, 3'd1, '0});
        queue_item(t_item'{ACT_READ, 32'h0, 16'h0, 3'd2, '0});
        queue_item(t_item'{ACT_INVAL, 32'h3, 16'h7, 3'd1, '0});
        wait_drain();

        // long receiver hold-off while the sender keeps offering
        hold_off = 300;
        for (int k = 0; k < 30; k++) queue_item(rand_item(1));
        wait_drain();

        for (int k = 0; k < 330; k++) queue_item(rand_item($urandom_range(0, 4) != 0));
        wait_drain();
        quiet = 1;
        for (int k = 0; k < 80; k++) queue_item(rand_item($urandom_range(0, 4) != 0));
        wait_drain();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
